FILE: rtl/itr_pkg.sv
// shared types, constants and symbol tables for the integer to roman numeral converter
package itr_pkg;

  localparam int unsigned VALUE_W = 12;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned MULT_W  = 14;
  localparam int unsigned MAX_VALUE = 3999;
  localparam int unsigned MAX_DIGIT = 9;

  localparam logic [1:0] PLACE_ONES      = 2'd0;
  localparam logic [1:0] PLACE_TENS      = 2'd1;
  localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
  localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

  localparam logic [1:0] SLOT_ONE  = 2'd0;
  localparam logic [1:0] SLOT_FIVE = 2'd1;
  localparam logic [1:0] SLOT_TEN  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_I    = 8'h49;
  localparam logic [CHAR_W-1:0] CHAR_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CHAR_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CHAR_L    = 8'h4C;
  localparam logic [CHAR_W-1:0] CHAR_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_D    = 8'h44;
  localparam logic [CHAR_W-1:0] CHAR_M    = 8'h4D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_ERR
  } itr_state_t;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic [1:0] conv_place;
    logic       conv_last;
    logic       emit;
    logic       emit_err;
  } itr_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic out_free;
    logic emit_last;
  } itr_stat_t;

  // number of letters for one decimal digit
  function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [2:0] n;
    case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // symbol slot of one letter position within a digit
  function automatic logic [1:0] digit_slot(input logic [DIGIT_W-1:0] d,
                                            input logic [1:0] idx);
    logic [1:0] s;
    s = SLOT_ONE;
    if (d == 4'd4) begin
      s = (idx == 2'd1) ? SLOT_FIVE : SLOT_ONE;
    end else if (d == 4'd9) begin
      s = (idx == 2'd1) ? SLOT_TEN : SLOT_ONE;
    end else if (d inside {[4'd5:4'd8]}) begin
      s = (idx == 2'd0) ? SLOT_FIVE : SLOT_ONE;
    end
    return s;
  endfunction

  // letter for a place and slot
  function automatic logic [CHAR_W-1:0] place_sym(input logic [1:0] p,
                                                  input logic [1:0] slot);
    logic [CHAR_W-1:0] c;
    case (p)
      PLACE_ONES: begin
        case (slot)
          SLOT_FIVE: c = CHAR_V;
          SLOT_TEN:  c = CHAR_X;
          default:   c = CHAR_I;
        endcase
      end
      PLACE_TENS: begin
        case (slot)
          SLOT_FIVE: c = CHAR_L;
          SLOT_TEN:  c = CHAR_C;
          default:   c = CHAR_X;
        endcase
      end
      PLACE_HUNDREDS: begin
        case (slot)
          SLOT_FIVE: c = CHAR_D;
          SLOT_TEN:  c = CHAR_M;
          default:   c = CHAR_C;
        endcase
      end
      default: c = CHAR_M;
    endcase
    return c;
  endfunction

  // k times the weight of a place; k is a constant at each call site
  function automatic logic [MULT_W-1:0] place_multiple(input logic [1:0] p,
                                                       input logic [DIGIT_W-1:0] k);
    logic [MULT_W-1:0] m;
    case (p)
      PLACE_THOUSANDS: m = MULT_W'(k) * 14'd1000;
      PLACE_HUNDREDS:  m = MULT_W'(k) * 14'd100;
      PLACE_TENS:      m = MULT_W'(k) * 14'd10;
      default:         m = MULT_W'(k);
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/itr_ctrl.sv
// controller state machine sequencing load, digit conversion and letter output
module itr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itr_pkg::itr_stat_t stat,
  output itr_pkg::itr_cmd_t  cmd
);
  import itr_pkg::*;

  itr_state_t state_r, state_nxt;
  logic [1:0] conv_cnt_r, conv_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      conv_cnt_r <= PLACE_THOUSANDS;
    end else begin
      state_r    <= state_nxt;
      conv_cnt_r <= conv_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    conv_cnt_nxt = conv_cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.conv_place = conv_cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          conv_cnt_nxt = PLACE_THOUSANDS;
          state_nxt    = stat.in_bad ? ST_ERR : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv      = 1'b1;
        cmd.conv_last = (conv_cnt_r == PLACE_TENS);
        if (conv_cnt_r == PLACE_TENS) begin
          state_nxt = ST_EMIT;
        end else begin
          conv_cnt_nxt = conv_cnt_r - 2'd1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/itr_dp.sv
// datapath: digit extraction, letter selection and output register
module itr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [itr_pkg::VALUE_W-1:0]  in_value,
  input  itr_pkg::itr_cmd_t            cmd,
  output itr_pkg::itr_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [itr_pkg::CHAR_W-1:0]   out_character,
  output logic                         out_last,
  output logic                         out_out_of_range
);
  import itr_pkg::*;

  typedef logic [3:0][DIGIT_W-1:0] digits_t;

  logic [VALUE_W-1:0] rem_r, rem_nxt;
  digits_t            digits_r, digits_nxt;
  logic [1:0]         place_r;
  logic [1:0]         idx_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;
  logic               out_oor_r;

  logic [DIGIT_W-1:0] conv_digit;
  logic [MULT_W-1:0]  conv_sub;
  logic [DIGIT_W-1:0] cur_digit;
  logic [2:0]         cur_len;
  logic [CHAR_W-1:0]  cur_char;
  logic               digit_done;
  logic               lower_nz;

  // highest place below lim holding a nonzero digit
  function automatic logic [1:0] highest_nz(input digits_t dg, input logic [2:0] lim);
    logic [1:0] res;
    res = PLACE_ONES;
    for (int q = 0; q < 4; q++) begin
      if (3'(q) < lim && dg[q] != '0) begin
        res = 2'(q);
      end
    end
    return res;
  endfunction

  // one decimal digit per cycle by parallel compare against its multiples
  always_comb begin
    conv_digit = '0;
    conv_sub   = '0;
    for (int k = 1; k <= int'(MAX_DIGIT); k++) begin
      if ({2'b00, rem_r} >= place_multiple(cmd.conv_place, DIGIT_W'(k))) begin
        conv_digit = DIGIT_W'(k);
        conv_sub   = place_multiple(cmd.conv_place, DIGIT_W'(k));
      end
    end
    rem_nxt    = rem_r - conv_sub[VALUE_W-1:0];
    digits_nxt = digits_r;
    digits_nxt[cmd.conv_place] = conv_digit;
    if (cmd.conv_last) begin
      digits_nxt[PLACE_ONES] = rem_nxt[DIGIT_W-1:0];
    end
  end

  always_comb begin
    cur_digit  = digits_r[place_r];
    cur_len    = digit_len(cur_digit);
    cur_char   = place_sym(place_r, digit_slot(cur_digit, idx_r));
    digit_done = ({1'b0, idx_r} == (cur_len - 3'd1));
    lower_nz   = 1'b0;
    for (int q = 0; q < 4; q++) begin
      if (2'(q) < place_r && digits_r[q] != '0) begin
        lower_nz = 1'b1;
      end
    end
  end

  assign stat.in_bad    = (in_value == '0) || (in_value > VALUE_W'(MAX_VALUE));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.emit_last = digit_done && !lower_nz;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= in_value;
    end else if (cmd.conv) begin
      rem_r <= rem_nxt;
    end
    if (cmd.conv) begin
      digits_r <= digits_nxt;
    end
    if (cmd.conv && cmd.conv_last) begin
      place_r <= highest_nz(digits_nxt, 3'd4);
      idx_r   <= 2'd0;
    end else if (cmd.emit) begin
      if (digit_done) begin
        place_r <= highest_nz(digits_r, {1'b0, place_r});
        idx_r   <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= cur_char;
      out_last_r <= stat.emit_last;
      out_oor_r  <= 1'b0;
    end else if (cmd.emit_err) begin
      out_char_r <= CHAR_NONE;
      out_last_r <= 1'b1;
      out_oor_r  <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_character    = out_char_r;
  assign out_last         = out_last_r;
  assign out_out_of_range = out_oor_r;

endmodule

FILE: rtl/integer_to_roman_numeral.sv
// top level of the integer to roman numeral converter
// usage:
//   in_value (12 bits) is taken with in_valid/in_ready; each item yields
//   one roman letter per out_valid/out_ready item, thousands first, with
//   out_last on the final letter of the numeral
//   values of 0 or above 3999 give one item with out_out_of_range and
//   out_last set and out_character 0
// timing:
//   one item at a time; in_ready is high only while the converter is idle
//   the thousands, hundreds and tens digits are extracted, one per cycle,
//   through the shared compare and subtract unit; letters then leave at
//   one per cycle from the output register while out_ready is high
// reset and stalls:
//   synchronous active low reset returns to idle and empties the output
//   register; a low out_ready holds the pending letter and stops output
//   generation until it is taken; the last letter may still wait while
//   the next item is accepted
module integer_to_roman_numeral (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [itr_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [itr_pkg::CHAR_W-1:0]  out_character,
  output logic                        out_last,
  output logic                        out_out_of_range
);
  import itr_pkg::*;

  itr_cmd_t  cmd;
  itr_stat_t stat;

  itr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_character    (out_character),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule

FILE: rtl/itr_chk.sv
// port level checker for the integer to roman numeral converter and its bind
module itr_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [itr_pkg::VALUE_W-1:0] in_value,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itr_pkg::CHAR_W-1:0]  out_character,
  input logic                        out_last,
  input logic                        out_out_of_range
);
  import itr_pkg::*;

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an item was taken");

  // a zero input, which is out of range, drops in_ready once taken
  a_err_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_value == '0)) |=> !in_ready)
    else $error("zero input not handled as a separate item");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_last && out_character == CHAR_NONE))
    else $error("error item malformed");

  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |->
      (out_character == CHAR_I || out_character == CHAR_V ||
       out_character == CHAR_X || out_character == CHAR_L ||
       out_character == CHAR_C || out_character == CHAR_D ||
       out_character == CHAR_M))
    else $error("output character is not a roman letter");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_character) &&
                                   $stable(out_last)))
    else $error("stalled output item changed");

endmodule

bind integer_to_roman_numeral itr_chk u_itr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_value         (in_value),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_character    (out_character),
  .out_last         (out_last),
  .out_out_of_range (out_out_of_range)
);
